// ===== design/vgm_command_stream_interpreter_core_defines.svh =====
// Assertion macros for the VGM command stream interpreter checker.
// Included by the checker file only; no other dependencies.
`ifndef VGM_COMMAND_STREAM_INTERPRETER_CORE_DEFINES_SVH
`define VGM_COMMAND_STREAM_INTERPRETER_CORE_DEFINES_SVH

// Clocked check, masked while reset is asserted.
`define VGM_CSI_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("vgm_csi check failed");

// Clocked check that also holds across reset.
`define VGM_CSI_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("vgm_csi check failed");

`endif

// ===== design/vgm_csi_pkg.sv =====
// Shared types, command codes and helpers for the VGM command stream interpreter.
// No dependencies; imported by the parser, the line divider and the top level.
`timescale 1ns / 1ps

package vgm_csi_pkg;

   typedef enum logic [2:0] {
      KIND_WAIT    = 3'd0,
      KIND_PORT    = 3'd1,
      KIND_MEM     = 3'd2,
      KIND_END     = 3'd3,
      KIND_UNKNOWN = 3'd4
   } kind_type;

   localparam logic [7:0] CMD_WAIT_LONG  = 8'h61;
   localparam logic [7:0] CMD_WAIT_NTSC  = 8'h62;
   localparam logic [7:0] CMD_WAIT_PAL   = 8'h63;
   localparam logic [7:0] CMD_END        = 8'h66;
   localparam logic [7:0] CMD_DATA_BLOCK = 8'h67;
   localparam logic [7:0] CMD_STREAM_0   = 8'h90;
   localparam logic [7:0] CMD_STREAM_1   = 8'h91;
   localparam logic [7:0] CMD_STREAM_2   = 8'h92;
   localparam logic [7:0] CMD_STREAM_3   = 8'h93;
   localparam logic [7:0] CMD_STREAM_4   = 8'h94;
   localparam logic [7:0] CMD_STREAM_5   = 8'h95;
   localparam logic [7:0] CMD_PORT_WRITE = 8'hBC;
   localparam logic [7:0] CMD_MEM_WRITE  = 8'hC6;
   localparam logic [3:0] CMD_SHORT_WAIT = 4'h7;

   localparam logic [15:0] SAMPLES_NTSC = 16'd735;
   localparam logic [15:0] SAMPLES_PAL  = 16'd882;

   localparam logic [7:0] PORT_SKIP_A   = 8'h0F;
   localparam logic [7:0] PORT_SKIP_B   = 8'h11;
   localparam logic [7:0] PORT_DMA_CTRL = 8'h10;
   localparam int         DMA_ON_BIT    = 5;

   // lines = (samples*120 + 440) / 441; the divide is a multiply by
   // ceil(2^32/441) + 1, exact for every dividend below 2^32/500.
   localparam logic [22:0] LINES_ROUND = 23'd440;
   localparam logic [23:0] LINES_RECIP = 24'd9739156;
   localparam int          LINES_SHIFT = 32;

   localparam logic [2:0] CSR_WAVE_BASE = 3'd0;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] samples;
      logic [7:0]  port_offset;
      logic [15:0] mem_address;
      logic [7:0]  write_data;
      logic        stop_dma;
   } result_type;

   function automatic logic [3:0] operand_count(input logic [7:0] cmd);
      logic [3:0] cnt;
      unique case (cmd)
         CMD_WAIT_LONG:  cnt = 4'd2;
         CMD_PORT_WRITE: cnt = 4'd2;
         CMD_MEM_WRITE:  cnt = 4'd3;
         CMD_DATA_BLOCK: cnt = 4'd6;
         CMD_STREAM_0:   cnt = 4'd4;
         CMD_STREAM_1:   cnt = 4'd4;
         CMD_STREAM_2:   cnt = 4'd5;
         CMD_STREAM_3:   cnt = 4'd10;
         CMD_STREAM_4:   cnt = 4'd1;
         CMD_STREAM_5:   cnt = 4'd4;
         default:        cnt = 4'd0;
      endcase
      return cnt;
   endfunction

endpackage

// ===== design/vgm_csi_parser.sv =====
// Byte-level command parser: holds the stream state and decodes one byte per cycle.
// Depends on vgm_csi_pkg.
`timescale 1ns / 1ps

module vgm_csi_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [7:0]              stream_byte,
   input  logic [7:0]              wave_base,
   output logic                    emit,
   output vgm_csi_pkg::result_type result
);
   import vgm_csi_pkg::*;

   logic [7:0]  cmd_ff, cmd_in;
   logic [31:0] bytes_left_ff, bytes_left_in;
   logic [7:0]  op_first_ff, op_first_in;
   logic [7:0]  op_second_ff, op_second_in;
   logic [31:0] block_len_ff, block_len_in;
   logic        halted_ff, halted_in;
   logic [3:0]  new_count;
   logic [15:0] long_samples;

   assign new_count    = operand_count(stream_byte);
   assign long_samples = {stream_byte, op_first_ff};

   always_comb begin
      cmd_in        = cmd_ff;
      bytes_left_in = bytes_left_ff;
      op_first_in   = op_first_ff;
      op_second_in  = op_second_ff;
      block_len_in  = block_len_ff;
      halted_in     = halted_ff;
      emit          = 1'b0;
      result        = '0;
      result.kind   = KIND_WAIT;

      if (accept && !halted_ff) begin
         if (bytes_left_ff == 32'd0) begin
            cmd_in = stream_byte;
            priority if (stream_byte[7:4] == CMD_SHORT_WAIT) begin
               emit           = 1'b1;
               result.samples = {12'd0, stream_byte[3:0]} + 16'd1;
            end else if (stream_byte == CMD_WAIT_NTSC) begin
               emit           = 1'b1;
               result.samples = SAMPLES_NTSC;
            end else if (stream_byte == CMD_WAIT_PAL) begin
               emit           = 1'b1;
               result.samples = SAMPLES_PAL;
            end else if (stream_byte == CMD_END) begin
               emit        = 1'b1;
               result.kind = KIND_END;
            end else if (new_count == 4'd0) begin
               halted_in   = 1'b1;
               emit        = 1'b1;
               result.kind = KIND_UNKNOWN;
            end else begin
               bytes_left_in = {28'd0, new_count};
               op_first_in   = 8'd0;
               op_second_in  = 8'd0;
               if (stream_byte == CMD_DATA_BLOCK) begin
                  block_len_in = 32'd0;
               end
            end
         end else if (cmd_ff == CMD_DATA_BLOCK && op_first_ff == 8'd1) begin
            // skipping data block payload
            bytes_left_in = bytes_left_ff - 32'd1;
            if (bytes_left_ff == 32'd1) begin
               op_first_in = 8'd0;
            end
         end else begin
            bytes_left_in = bytes_left_ff - 32'd1;
            unique case (cmd_ff)
               CMD_WAIT_LONG: begin
                  if (bytes_left_ff == 32'd2) begin
                     op_first_in = stream_byte;
                  end else if (long_samples != 16'd0) begin
                     emit           = 1'b1;
                     result.samples = long_samples;
                  end
               end
               CMD_PORT_WRITE: begin
                  if (bytes_left_ff == 32'd2) begin
                     op_first_in = stream_byte;
                  end else if (op_first_ff != PORT_SKIP_A && op_first_ff != PORT_SKIP_B) begin
                     emit               = 1'b1;
                     result.kind        = KIND_PORT;
                     result.port_offset = op_first_ff;
                     result.write_data  = stream_byte;
                     result.stop_dma    = (op_first_ff == PORT_DMA_CTRL)
                                          && !stream_byte[DMA_ON_BIT];
                  end
               end
               CMD_MEM_WRITE: begin
                  if (bytes_left_ff == 32'd3) begin
                     op_first_in = stream_byte;
                  end else if (bytes_left_ff == 32'd2) begin
                     op_second_in = stream_byte;
                  end else begin
                     emit               = 1'b1;
                     result.kind        = KIND_MEM;
                     result.mem_address = {op_first_ff, op_second_ff}
                                          + {2'b00, wave_base, 6'd0};
                     result.write_data  = stream_byte;
                  end
               end
               CMD_DATA_BLOCK: begin
                  // header bytes 2..5 carry the little-endian payload length
                  unique case (bytes_left_ff)
                     32'd4:   block_len_in[7:0]   = stream_byte;
                     32'd3:   block_len_in[15:8]  = stream_byte;
                     32'd2:   block_len_in[23:16] = stream_byte;
                     32'd1:   block_len_in[31:24] = stream_byte;
                     default: block_len_in        = block_len_ff;
                  endcase
                  if (bytes_left_ff == 32'd1 && block_len_in != 32'd0) begin
                     bytes_left_in = block_len_in;
                     op_first_in   = 8'd1;
                  end
               end
               default: begin
                  // stream control commands: operands are skipped
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff        <= 8'd0;
         bytes_left_ff <= 32'd0;
         op_first_ff   <= 8'd0;
         op_second_ff  <= 8'd0;
         block_len_ff  <= 32'd0;
         halted_ff     <= 1'b0;
      end else begin
         cmd_ff        <= cmd_in;
         bytes_left_ff <= bytes_left_in;
         op_first_ff   <= op_first_in;
         op_second_ff  <= op_second_in;
         block_len_ff  <= block_len_in;
         halted_ff     <= halted_in;
      end
   end

endmodule

// ===== design/vgm_csi_lines.sv =====
// Sample count to display line conversion, one registered multiply stage.
// Depends on vgm_csi_pkg.
`timescale 1ns / 1ps

module vgm_csi_lines (
   input  logic        clock,
   input  logic        enable,
   input  logic [15:0] samples,
   output logic [14:0] lines
);
   import vgm_csi_pkg::*;

   logic [22:0] dividend;
   logic [46:0] product;
   logic [14:0] lines_ff;

   // samples*120 as (s<<7) - (s<<3); a zero count yields zero lines
   assign dividend = {samples, 7'd0} - {4'd0, samples, 3'd0} + LINES_ROUND;
   assign product  = {24'd0, dividend} * {23'd0, LINES_RECIP};

   always_ff @(posedge clock) begin
      if (enable) begin
         lines_ff <= product[LINES_SHIFT +: 15];
      end
   end

   assign lines = lines_ff;

endmodule

// ===== design/vgm_command_stream_interpreter_core.sv =====
// VGM command stream interpreter: one stream byte per request.
// Throughput: one request per cycle unless stalled; req_stall rises only when
// both the decode register and the result register are full and rsp_stall is high.
// Results go through the decode register, then the line multiply into the result
// register, after the byte that completes their command.
// Reset (synchronous): parser state, halt flag and wave_base clear; pipeline empties.
`timescale 1ns / 1ps

module vgm_command_stream_interpreter_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_stream_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [14:0] rsp_wait_lines,
   output logic [7:0]  rsp_port_offset,
   output logic [15:0] rsp_mem_address,
   output logic [7:0]  rsp_write_data,
   output logic        rsp_stop_dma,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import vgm_csi_pkg::*;

   logic [7:0] wave_base_reg_ff, wave_base_reg_in;
   logic       accept;
   logic       emit;
   result_type parse_result;
   logic       s1_valid_ff, s1_valid_in;
   result_type s1_ff;
   logic       out_valid_ff, out_valid_in;
   logic       out_en, s1_en;
   kind_type   out_kind_ff;
   logic [7:0] out_port_ff;
   logic [15:0] out_mem_ff;
   logic [7:0] out_data_ff;
   logic       out_stop_ff;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_WAVE_BASE) ? {24'd0, wave_base_reg_ff} : 32'd0;

   always_comb begin
      wave_base_reg_in = wave_base_reg_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr == CSR_WAVE_BASE) begin
         wave_base_reg_in = csr_pwdata[7:0];
      end
   end

   // two-stage pipeline, each stage loads when it is empty or draining
   assign out_en    = !out_valid_ff || !rsp_stall;
   assign s1_en     = !s1_valid_ff || out_en;
   assign req_stall = !s1_en;
   assign accept    = req_valid && s1_en;

   assign s1_valid_in  = s1_en ? (accept && emit) : s1_valid_ff;
   assign out_valid_in = out_en ? s1_valid_ff : out_valid_ff;

   vgm_csi_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .stream_byte (req_stream_byte),
      .wave_base   (wave_base_reg_ff),
      .emit        (emit),
      .result      (parse_result)
   );

   vgm_csi_lines u_lines (
      .clock   (clock),
      .enable  (out_en),
      .samples (s1_ff.samples),
      .lines   (rsp_wait_lines)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_base_reg_ff <= 8'd0;
         s1_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
      end else begin
         wave_base_reg_ff <= wave_base_reg_in;
         s1_valid_ff      <= s1_valid_in;
         out_valid_ff     <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_ff <= parse_result;
      end
      if (out_en) begin
         out_kind_ff <= s1_ff.kind;
         out_port_ff <= s1_ff.port_offset;
         out_mem_ff  <= s1_ff.mem_address;
         out_data_ff <= s1_ff.write_data;
         out_stop_ff <= s1_ff.stop_dma;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_kind        = out_kind_ff;
   assign rsp_port_offset = out_port_ff;
   assign rsp_mem_address = out_mem_ff;
   assign rsp_write_data  = out_data_ff;
   assign rsp_stop_dma    = out_stop_ff;

endmodule

// ===== design/vgm_csi_checker.sv =====
// Port-level checks for the VGM command stream interpreter, bound to the top level.
// Depends on vgm_csi_pkg and vgm_command_stream_interpreter_core_defines.svh.
`timescale 1ns / 1ps
`include "vgm_command_stream_interpreter_core_defines.svh"

module vgm_csi_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_kind,
   input logic [14:0] rsp_wait_lines,
   input logic [7:0]  rsp_port_offset,
   input logic [15:0] rsp_mem_address,
   input logic [7:0]  rsp_write_data,
   input logic        rsp_stop_dma
);
   import vgm_csi_pkg::*;

   logic [50:0] rsp_payload;
   logic        rsp_held;
   logic        rsp_is_wait;
   logic        rsp_not_port;

   assign rsp_payload  = {rsp_kind, rsp_wait_lines, rsp_port_offset, rsp_mem_address,
                          rsp_write_data, rsp_stop_dma};
   assign rsp_held     = rsp_valid && rsp_stall;
   assign rsp_is_wait  = rsp_valid && rsp_kind == KIND_WAIT;
   assign rsp_not_port = rsp_valid && rsp_kind != KIND_PORT;

   `VGM_CSI_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_valid)

   `VGM_CSI_ASSERT(a_rsp_hold, clock, reset, rsp_held |=> rsp_valid && $stable(rsp_payload))

   `VGM_CSI_ASSERT(a_wait_nonzero, clock, reset, rsp_is_wait |-> rsp_wait_lines != 15'd0)

   `VGM_CSI_ASSERT(a_dma_only_port, clock, reset, rsp_not_port |-> !rsp_stop_dma)

   `VGM_CSI_ASSERT(a_stall_backpressure, clock, reset, req_stall |-> rsp_valid && rsp_stall)

endmodule

bind vgm_command_stream_interpreter_core vgm_csi_checker u_vgm_csi_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_kind        (rsp_kind),
   .rsp_wait_lines  (rsp_wait_lines),
   .rsp_port_offset (rsp_port_offset),
   .rsp_mem_address (rsp_mem_address),
   .rsp_write_data  (rsp_write_data),
   .rsp_stop_dma    (rsp_stop_dma)
);

// ===== test/tb.sv =====
// Self-checking testbench for vgm_command_stream_interpreter_core.
// Depends on vgm_csi_pkg (result kinds, command codes, CSR index) and the core RTL.
`timescale 1ns / 1ps

module tb;
   import vgm_csi_pkg::*;

   typedef struct packed {
      kind_type    kind;
      logic [14:0] lines;
      logic [7:0]  port;
      logic [15:0] addr;
      logic [7:0]  data;
      logic        dma;
   } player_result_type;

   localparam int QUIET_LIMIT = 3000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_stream_byte = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_kind;
   logic [14:0] rsp_wait_lines;
   logic [7:0]  rsp_port_offset;
   logic [15:0] rsp_mem_address;
   logic [7:0]  rsp_write_data;
   logic        rsp_stop_dma;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   vgm_command_stream_interpreter_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_stream_byte(req_stream_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_kind(rsp_kind),
      .rsp_wait_lines(rsp_wait_lines), .rsp_port_offset(rsp_port_offset),
      .rsp_mem_address(rsp_mem_address), .rsp_write_data(rsp_write_data),
      .rsp_stop_dma(rsp_stop_dma),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // parser mirror
   logic [7:0]  wave_base = '0;
   logic [7:0]  pending_cmd = '0;
   int unsigned operands_due = 0;
   logic [7:0]  first_op = '0;
   logic [7:0]  second_op = '0;
   logic [31:0] blk_len = '0;
   bit          in_payload = 1'b0;
   bit          halted = 1'b0;

   player_result_type due_results[$];
   int  errors = 0;
   int  bytes_sent = 0;
   int  kind_seen[5] = '{default: 0};
   int  base_settings = 0;
   bit  idle_on = 1'b1;
   int  hold_len = 0;
   int  quiet = 0;

   function automatic int unsigned bytes_after(input logic [7:0] cmd);
      case (cmd)
         CMD_WAIT_LONG, CMD_PORT_WRITE:            return 2;
         CMD_MEM_WRITE:                            return 3;
         CMD_DATA_BLOCK:                           return 6;
         CMD_STREAM_0, CMD_STREAM_1, CMD_STREAM_5: return 4;
         CMD_STREAM_2:                             return 5;
         CMD_STREAM_3:                             return 10;
         CMD_STREAM_4:                             return 1;
         default:                                  return 0;
      endcase
   endfunction

   function automatic bit wait_result(input int unsigned samples,
                                      output player_result_type r);
      r = '0;
      r.kind = KIND_WAIT;
      r.lines = 15'((samples * 120 + 440) / 441);
      return samples != 0;
   endfunction

   // Advances the parser by one stream byte; returns 1 when a result is due.
   function automatic bit interpret_byte(input logic [7:0] b, output player_result_type r);
      int unsigned pos;
      r = '0;
      if (halted) return 1'b0;
      if (operands_due == 0) begin
         pending_cmd = b;
         if (b[7:4] == CMD_SHORT_WAIT) return wait_result(int'(b[3:0]) + 1, r);
         if (b == CMD_WAIT_NTSC) return wait_result(SAMPLES_NTSC, r);
         if (b == CMD_WAIT_PAL) return wait_result(SAMPLES_PAL, r);
         if (b == CMD_END) begin
            r.kind = KIND_END;
            return 1'b1;
         end
         operands_due = bytes_after(b);
         if (operands_due == 0) begin
            halted = 1'b1;
            r.kind = KIND_UNKNOWN;
            return 1'b1;
         end
         first_op = '0;
         second_op = '0;
         if (b == CMD_DATA_BLOCK) blk_len = '0;
         return 1'b0;
      end
      if (pending_cmd == CMD_DATA_BLOCK && in_payload) begin
         operands_due--;
         if (operands_due == 0) in_payload = 1'b0;
         return 1'b0;
      end
      pos = bytes_after(pending_cmd) - operands_due;
      operands_due--;
      case (pending_cmd)
         CMD_WAIT_LONG: begin
            if (pos == 0) begin
               first_op = b;
               return 1'b0;
            end
            return wait_result({b, first_op}, r);
         end
         CMD_PORT_WRITE: begin
            if (pos == 0) begin
               first_op = b;
               return 1'b0;
            end
            if (first_op == PORT_SKIP_A || first_op == PORT_SKIP_B) return 1'b0;
            r.kind = KIND_PORT;
            r.port = first_op;
            r.data = b;
            r.dma = (first_op == PORT_DMA_CTRL) && !b[DMA_ON_BIT];
            return 1'b1;
         end
         CMD_MEM_WRITE: begin
            if (pos == 0) begin
               first_op = b;
               return 1'b0;
            end
            if (pos == 1) begin
               second_op = b;
               return 1'b0;
            end
            r.kind = KIND_MEM;
            r.addr = {first_op, second_op} + {2'b00, wave_base, 6'b000000};
            r.data = b;
            return 1'b1;
         end
         CMD_DATA_BLOCK: begin
            // header: compat byte, type byte, then 32-bit little-endian length
            if (pos >= 2 && pos <= 5) blk_len |= 32'(b) << (8 * (pos - 2));
            if (operands_due == 0 && blk_len != 0) begin
               operands_due = blk_len;
               in_payload = 1'b1;
            end
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   function automatic bit is_known_command(input logic [7:0] b);
      return bytes_after(b) != 0 || b[7:4] == CMD_SHORT_WAIT || b == CMD_WAIT_NTSC ||
             b == CMD_WAIT_PAL || b == CMD_END;
   endfunction

   task automatic send_byte(input logic [7:0] b);
      player_result_type r;
      if (idle_on && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_stream_byte <= b;
      do @(posedge clock); while (req_stall);
      if (interpret_byte(b, r)) due_results.push_back(r);
      bytes_sent++;
   endtask

   // Sender goes quiet until every predicted result is out, plus pipeline slack.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_wave_base(input logic [7:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_WAVE_BASE;
      csr_pwdata <= {24'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      wave_base = value;
      base_settings++;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[7:0] !== value) begin
         $error("wave_base readback: expected %0h, actual %0h", value, csr_prdata[7:0]);
         errors++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : check_results
      player_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_results.size() == 0) begin
            $error("result with nothing pending: kind %0d", rsp_kind);
            errors++;
         end else begin
            want = due_results.pop_front();
            check_field("kind", want.kind, rsp_kind);
            check_field("wait_lines", want.lines, rsp_wait_lines);
            check_field("port_offset", want.port, rsp_port_offset);
            check_field("mem_address", want.addr, rsp_mem_address);
            check_field("write_data", want.data, rsp_write_data);
            check_field("stop_dma", want.dma, rsp_stop_dma);
            kind_seen[want.kind]++;
         end
      end
   end

   // receiver: random stall bursts, or one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_len != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_len) @(posedge clock);
            hold_len = 0;
            rsp_stall <= 1'b0;
         end else if (idle_on && !reset && $urandom_range(0, 11) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   task automatic test_waits();
      send_byte({CMD_SHORT_WAIT, 4'h0});
      send_byte({CMD_SHORT_WAIT, 4'hF});
      send_byte(CMD_WAIT_NTSC);
      send_byte(CMD_WAIT_PAL);
      send_byte(CMD_WAIT_LONG); send_byte(8'h00); send_byte(8'h00);  // zero wait, silent
      send_byte(CMD_WAIT_LONG); send_byte(8'hFF); send_byte(8'hFF);
      send_byte(CMD_WAIT_LONG); send_byte(8'h01); send_byte(8'h00);
   endtask

   task automatic test_port_writes();
      send_byte(CMD_PORT_WRITE); send_byte(PORT_SKIP_A); send_byte(8'h12);
      send_byte(CMD_PORT_WRITE); send_byte(PORT_SKIP_B); send_byte(8'h34);
      send_byte(CMD_PORT_WRITE); send_byte(PORT_DMA_CTRL); send_byte(8'h00);
      send_byte(CMD_PORT_WRITE); send_byte(PORT_DMA_CTRL); send_byte(8'h20);
      send_byte(CMD_PORT_WRITE); send_byte(8'hFF); send_byte(8'hFF);
      send_byte(CMD_PORT_WRITE); send_byte(8'h00); send_byte(8'hDF);
   endtask

   task automatic test_mem_writes();
      drain_results();
      write_wave_base(8'hFF);
      send_byte(CMD_MEM_WRITE); send_byte(8'hFF); send_byte(8'hFF); send_byte(8'h5A);
      send_byte(CMD_MEM_WRITE); send_byte(8'h00); send_byte(8'h00); send_byte(8'hA5);
      drain_results();
      write_wave_base(8'h00);
      send_byte(CMD_MEM_WRITE); send_byte(8'h12); send_byte(8'h34); send_byte(8'hFF);
   endtask

   task automatic test_skipped_commands();
      logic [7:0] codes[6];
      codes = '{CMD_STREAM_0, CMD_STREAM_1, CMD_STREAM_2,
                CMD_STREAM_3, CMD_STREAM_4, CMD_STREAM_5};
      // operands that look like end-of-data must be swallowed
      foreach (codes[i]) begin
         send_byte(codes[i]);
         repeat (bytes_after(codes[i])) send_byte(CMD_END);
      end
      send_byte(CMD_WAIT_NTSC);
      // empty data block ends right after its header
      send_byte(CMD_DATA_BLOCK); send_byte(CMD_END); send_byte(8'h00);
      repeat (4) send_byte(8'h00);
      send_byte(CMD_WAIT_PAL);
      send_byte(CMD_DATA_BLOCK); send_byte(CMD_END); send_byte(8'h00);
      send_byte(8'h02); send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);
      send_byte(CMD_END); send_byte(CMD_END);
      send_byte({CMD_SHORT_WAIT, 4'h5});
   endtask

   task automatic test_end_of_data();
      send_byte(CMD_END);
      send_byte(CMD_END);
      send_byte({CMD_SHORT_WAIT, 4'h9});
   endtask

   task automatic test_backpressure();
      drain_results();
      idle_on = 1'b0;
      hold_len = 300;
      repeat (40) send_byte(CMD_WAIT_NTSC);
      drain_results();
      idle_on = 1'b1;
   endtask

   task automatic send_random_command();
      int          pick;
      logic [7:0]  cmd;
      logic [31:0] len;
      pick = $urandom_range(0, 99);
      if (pick < 14) begin
         send_byte({CMD_SHORT_WAIT, 4'($urandom_range(0, 15))});
      end else if (pick < 20) begin
         send_byte($urandom_range(0, 1) ? CMD_WAIT_NTSC : CMD_WAIT_PAL);
      end else if (pick < 32) begin
         send_byte(CMD_WAIT_LONG);
         if ($urandom_range(0, 7) == 0) begin
            send_byte(8'h00); send_byte(8'h00);
         end else begin
            send_byte(8'($urandom_range(0, 255))); send_byte(8'($urandom_range(0, 255)));
         end
      end else if (pick < 52) begin
         send_byte(CMD_PORT_WRITE);
         case ($urandom_range(0, 4))
            0:       send_byte(PORT_SKIP_A);
            1:       send_byte(PORT_SKIP_B);
            2:       send_byte(PORT_DMA_CTRL);
            default: send_byte(8'($urandom_range(0, 255)));
         endcase
         send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 70) begin
         send_byte(CMD_MEM_WRITE);
         repeat (3) send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 80) begin
         cmd = CMD_STREAM_0 + 8'($urandom_range(0, 5));
         send_byte(cmd);
         repeat (bytes_after(cmd)) send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 88) begin
         // mostly short blocks, now and then a few hundred bytes
         len = ($urandom_range(0, 15) == 0) ? $urandom_range(256, 511)
                                            : $urandom_range(0, 24);
         send_byte(CMD_DATA_BLOCK);
         send_byte(8'($urandom_range(0, 255)));
         send_byte(8'($urandom_range(0, 255)));
         send_byte(len[7:0]); send_byte(len[15:8]);
         send_byte(len[23:16]); send_byte(len[31:24]);
         repeat (len) send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 93) begin
         send_byte(CMD_END);
      end else begin
         send_byte(CMD_WAIT_NTSC);
      end
   endtask

   task automatic test_random_stream(input logic [7:0] base, input int n_bytes);
      int stop_at;
      drain_results();
      write_wave_base(base);
      stop_at = bytes_sent + n_bytes;
      while (bytes_sent < stop_at) send_random_command();
   endtask

   // Halts the parser for the rest of the run, so it goes last.
   task automatic test_unknown_command();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (is_known_command(b));
      send_byte(b);
      send_byte(CMD_WAIT_NTSC);
      send_byte(CMD_END);
      repeat (16) send_byte(8'($urandom_range(0, 255)));
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      write_wave_base(8'h00);
      test_waits();
      test_port_writes();
      test_mem_writes();
      test_skipped_commands();
      test_end_of_data();
      test_backpressure();
      test_random_stream(8'($urandom_range(1, 254)), 350);
      test_random_stream(8'hFF, 350);
      test_random_stream(8'h00, 300);
      idle_on = 1'b0;
      test_random_stream(8'h40, 200);
      test_unknown_command();
      drain_results();
      $display("summary: %0d stream bytes, %0d wave_base settings; checked %0d waits,",
               bytes_sent, base_settings, kind_seen[KIND_WAIT]);
      $display("summary: %0d port writes, %0d memory writes, %0d end marks, %0d unknown",
               kind_seen[KIND_PORT], kind_seen[KIND_MEM], kind_seen[KIND_END],
               kind_seen[KIND_UNKNOWN]);
      if (errors == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/vgm_csi_pkg.sv
design/vgm_csi_parser.sv
design/vgm_csi_lines.sv
design/vgm_command_stream_interpreter_core.sv
design/vgm_csi_checker.sv
test/tb.sv
